// File: hw/rtl/tbc_pkg.sv
// Shared constants and types of the triangle back-face cull block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tbc_pkg;

    localparam int COORD_W       = 24;
    localparam int IDX_W         = 10;
    localparam int TOTAL_W       = 11;
    localparam int MAX_TRIANGLES = 1024;

    // area = x0*(y1-y2) + x1*(y2-y0) + x2*(y0-y1)
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = COORD_W + DIFF_W;
    localparam int AREA_W = PROD_W + 2;

    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = 3;
    localparam int Q_CNT_W = 4;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // register select bit, paddr[2]
    localparam logic REG_FRONT_CW  = 1'b0;
    localparam logic REG_CULL_BACK = 1'b1;

    // classified triangle handed from the front to the back
    typedef struct packed {
        logic             keep;
        logic             batch_end;
        logic [IDX_W-1:0] tri_index;
    } t_cls;

endpackage

`default_nettype wire

// File: hw/rtl/tbc_if.sv
// Valid/ready channel interfaces: triangle requests in, kept-index results out.
// Depends on tbc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tbc_tri_if;
    logic                               valid;
    logic                               ready;
    logic signed [tbc_pkg::COORD_W-1:0] vert0_x;
    logic signed [tbc_pkg::COORD_W-1:0] vert0_y;
    logic signed [tbc_pkg::COORD_W-1:0] vert1_x;
    logic signed [tbc_pkg::COORD_W-1:0] vert1_y;
    logic signed [tbc_pkg::COORD_W-1:0] vert2_x;
    logic signed [tbc_pkg::COORD_W-1:0] vert2_y;
    logic        [tbc_pkg::IDX_W-1:0]   tri_index;
    logic                               batch_end;

    modport source (output valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                    tri_index, batch_end, input ready);
    modport sink   (input valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                    tri_index, batch_end, output ready);
endinterface

interface tbc_res_if;
    logic                         valid;
    logic                         ready;
    logic [tbc_pkg::IDX_W-1:0]    kept_index;
    logic                         index_valid;
    logic                         is_last;
    logic [tbc_pkg::TOTAL_W-1:0]  kept_total;

    modport source (output valid, kept_index, index_valid, is_last, kept_total,
                    input ready);
    modport sink   (input valid, kept_index, index_valid, is_last, kept_total,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tbc_front.sv
// Front part: accepts triangles, forms the signed area from differences, products, sum and sign, classifies.
// Depends on tbc_pkg and tbc_tri_if.
`timescale 1ns / 1ps
`default_nettype none

module tbc_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    tbc_tri_if.sink                          i_tri,
    input  wire logic                        i_front_cw,
    input  wire logic                        i_cull_back,
    input  wire logic [tbc_pkg::Q_CNT_W-1:0] i_q_count,
    output      logic                        o_push,
    output      tbc_pkg::t_cls               o_cls
);

    logic                               r_s1_valid;
    logic                               r_s2_valid;
    logic signed [tbc_pkg::COORD_W-1:0] r_x0, r_x1, r_x2;
    logic signed [tbc_pkg::DIFF_W-1:0]  r_d0, r_d1, r_d2;
    logic signed [tbc_pkg::PROD_W-1:0]  r_p0, r_p1, r_p2;
    logic        [tbc_pkg::IDX_W-1:0]   r_s1_idx, r_s2_idx;
    logic                               r_s1_end, r_s2_end;
    logic signed [tbc_pkg::PROD_W-1:0]  n_p0, n_p1, n_p2;
    logic signed [tbc_pkg::AREA_W-1:0]  n_area;
    logic        [tbc_pkg::Q_CNT_W-1:0] n_occupancy;
    logic                               n_accept;
    logic                               n_neg, n_pos, n_nz;

    // credit check: queue plus everything in flight must fit the queue
    assign n_occupancy = i_q_count + tbc_pkg::Q_CNT_W'(r_s1_valid)
                                   + tbc_pkg::Q_CNT_W'(r_s2_valid);
    assign i_tri.ready = (n_occupancy < tbc_pkg::Q_CNT_W'(tbc_pkg::Q_DEPTH));
    assign n_accept    = i_tri.valid && i_tri.ready;

    assign n_p0 = r_x0 * r_d0;
    assign n_p1 = r_x1 * r_d1;
    assign n_p2 = r_x2 * r_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0     <= i_tri.vert0_x;
        r_x1     <= i_tri.vert1_x;
        r_x2     <= i_tri.vert2_x;
        r_d0     <= tbc_pkg::DIFF_W'(i_tri.vert1_y) - tbc_pkg::DIFF_W'(i_tri.vert2_y);
        r_d1     <= tbc_pkg::DIFF_W'(i_tri.vert2_y) - tbc_pkg::DIFF_W'(i_tri.vert0_y);
        r_d2     <= tbc_pkg::DIFF_W'(i_tri.vert0_y) - tbc_pkg::DIFF_W'(i_tri.vert1_y);
        r_s1_idx <= i_tri.tri_index;
        r_s1_end <= i_tri.batch_end;
        r_p0     <= n_p0;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_s2_idx <= r_s1_idx;
        r_s2_end <= r_s1_end;
    end

    assign n_area = tbc_pkg::AREA_W'(r_p0) + tbc_pkg::AREA_W'(r_p1)
                  + tbc_pkg::AREA_W'(r_p2);
    assign n_nz   = (n_area != '0);
    // sign after the optional negation for clockwise front faces
    assign n_neg  = i_front_cw ? (n_nz && !n_area[tbc_pkg::AREA_W-1])
                               : n_area[tbc_pkg::AREA_W-1];
    assign n_pos  = n_nz && !n_neg;

    assign o_push          = r_s2_valid;
    assign o_cls.keep      = i_cull_back ? n_neg : n_pos;
    assign o_cls.batch_end = r_s2_end;
    assign o_cls.tri_index = r_s2_idx;

endmodule

`default_nettype wire

// File: hw/rtl/tbc_queue.sv
// Small flip-flop FIFO of classified triangles between front and back.
// Depends on tbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbc_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire tbc_pkg::t_cls               i_data,
    input  wire logic                        i_pop,
    output      tbc_pkg::t_cls               o_head,
    output      logic                        o_empty,
    output      logic                        o_full,
    output      logic [tbc_pkg::Q_CNT_W-1:0] o_count
);

    tbc_pkg::t_cls                   r_mem [tbc_pkg::Q_DEPTH];
    logic [tbc_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [tbc_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [tbc_pkg::Q_CNT_W-1:0]     r_count;
    logic [tbc_pkg::Q_CNT_W-1:0]     n_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == tbc_pkg::Q_CNT_W'(tbc_pkg::Q_DEPTH));
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tbc_back.sv
// Back part: keeps the batch count, compacts kept indices, pads odd batches,
// and drives the result register. Depends on tbc_pkg and tbc_res_if.
`timescale 1ns / 1ps
`default_nettype none

module tbc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tbc_pkg::t_cls i_head,
    input  wire logic          i_empty,
    output      logic          o_pop,
    tbc_res_if.source          o_res
);

    logic [tbc_pkg::TOTAL_W-1:0] r_count;
    logic [tbc_pkg::IDX_W-1:0]   r_last;
    logic                        r_pend;
    logic [tbc_pkg::IDX_W-1:0]   r_pend_idx;
    logic [tbc_pkg::TOTAL_W-1:0] r_pend_total;
    logic                        r_out_valid;
    logic [tbc_pkg::IDX_W-1:0]   r_out_idx;
    logic                        r_out_idx_valid;
    logic                        r_out_last;
    logic [tbc_pkg::TOTAL_W-1:0] r_out_total;

    logic                        n_keep;
    logic [tbc_pkg::TOTAL_W-1:0] n_cnt;
    logic [tbc_pkg::TOTAL_W-1:0] n_cnt_pad;
    logic [tbc_pkg::IDX_W-1:0]   n_last;
    logic                        n_has_res;
    logic                        n_two;
    logic                        n_slot;
    logic [tbc_pkg::IDX_W-1:0]   n_idx;
    logic                        n_idx_valid;
    logic                        n_is_last;
    logic [tbc_pkg::TOTAL_W-1:0] n_total;

    // kept triangles past capacity are dropped
    assign n_keep    = i_head.keep
                    && (r_count < tbc_pkg::TOTAL_W'(tbc_pkg::MAX_TRIANGLES));
    assign n_cnt     = r_count + tbc_pkg::TOTAL_W'(n_keep);
    assign n_cnt_pad = n_cnt + 1'b1;
    assign n_last    = n_keep ? i_head.tri_index : r_last;
    assign n_has_res = n_keep || i_head.batch_end;
    // kept item that makes an odd batch end: index, then padding repeat
    assign n_two     = n_keep && i_head.batch_end && n_cnt[0];

    assign n_slot = !r_out_valid || o_res.ready;
    assign o_pop  = !i_empty && !r_pend && (n_slot || !n_has_res);

    always_comb begin
        n_idx       = i_head.tri_index;
        n_idx_valid = 1'b1;
        n_is_last   = 1'b0;
        n_total     = '0;
        if (i_head.batch_end && !n_two) begin
            n_is_last = 1'b1;
            if (n_cnt[0]) begin
                n_idx   = n_last;
                n_total = n_cnt_pad;
            end else begin
                n_idx       = n_keep ? i_head.tri_index : '0;
                n_idx_valid = n_keep;
                n_total     = n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count <= i_head.batch_end ? '0 : n_cnt;
                r_last  <= i_head.batch_end ? '0 : n_last;
            end
            if (n_slot) begin
                if (r_pend) begin
                    r_out_valid <= 1'b1;
                    r_pend      <= 1'b0;
                end else if (o_pop && n_has_res) begin
                    r_out_valid <= 1'b1;
                    r_pend      <= n_two;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_slot) begin
            if (r_pend) begin
                r_out_idx       <= r_pend_idx;
                r_out_idx_valid <= 1'b1;
                r_out_last      <= 1'b1;
                r_out_total     <= r_pend_total;
            end else begin
                r_out_idx       <= n_idx;
                r_out_idx_valid <= n_idx_valid;
                r_out_last      <= n_is_last;
                r_out_total     <= n_total;
            end
        end
        if (o_pop) begin
            r_pend_idx   <= i_head.tri_index;
            r_pend_total <= n_cnt_pad;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kept_index  = r_out_idx;
    assign o_res.index_valid = r_out_idx_valid;
    assign o_res.is_last     = r_out_last;
    assign o_res.kept_total  = r_out_total;

endmodule

`default_nettype wire

// File: hw/rtl/triangle_backface_cull_compact.sv
// Top level: APB registers, front classifier, queue and back compactor.
// Depends on tbc_pkg, tbc_if, tbc_front, tbc_queue, tbc_back.
//
//   channel  dir  handshake            carries
//   i_tri    in   valid/ready          three xy vertices, tri_index, batch_end
//   o_res    out  valid/ready          kept_index, index_valid, is_last, kept_total
//   apb      in   psel/penable/pready  front_is_clockwise (0x0), cull_back_faces (0x4)
//
// One triangle per cycle enters while queue credits allow; its area is formed as
// differences, products, then sum and sign before it lands in an 8-entry queue.
// The back drains one queue entry per cycle while the result slot is free; a kept
// triangle closing an odd batch yields two results; the queue waits for the second.
// Input ready follows queue credits, so output stalls never reach it combinationally.
// Reset is synchronous, active low; counts, queue and config return to defaults.
`timescale 1ns / 1ps
`default_nettype none

module triangle_backface_cull_compact (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tbc_tri_if.sink                             i_tri,
    tbc_res_if.source                           o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tbc_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [tbc_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [tbc_pkg::APB_DATA_W-1:0] prdata,
    output      logic                           pready
);

    logic                        r_front_cw;
    logic                        r_cull_back;
    logic                        n_wr;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_empty;
    logic                        q_full;
    logic [tbc_pkg::Q_CNT_W-1:0] q_count;
    tbc_pkg::t_cls               q_in;
    tbc_pkg::t_cls               q_head;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_cw  <= 1'b0;
            r_cull_back <= 1'b1;
        end else if (n_wr) begin
            case (paddr[2])
                tbc_pkg::REG_FRONT_CW:  r_front_cw  <= pwdata[0];
                tbc_pkg::REG_CULL_BACK: r_cull_back <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            tbc_pkg::REG_FRONT_CW:  prdata = tbc_pkg::APB_DATA_W'(r_front_cw);
            tbc_pkg::REG_CULL_BACK: prdata = tbc_pkg::APB_DATA_W'(r_cull_back);
            default:                prdata = '0;
        endcase
    end

    tbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tri       (i_tri),
        .i_front_cw  (r_front_cw),
        .i_cull_back (r_cull_back),
        .i_q_count   (q_count),
        .o_push      (q_push),
        .o_cls       (q_in)
    );

    tbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    tbc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.index_valid) |-> o_res.is_last)
        else $error("end marker without is_last");

    a_even_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_last) |-> !o_res.kept_total[0])
        else $error("odd padded total");
`endif

endmodule

`default_nettype wire
